// File: src/path_bounding_box_defines.svh
// assertion macros for the path bounding box block
// included by path_bounding_box.sv; no other dependencies
`ifndef PATH_BOUNDING_BOX_DEFINES_SVH
`define PATH_BOUNDING_BOX_DEFINES_SVH
`ifndef SYNTHESIS
`define PBB_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("path_bounding_box: assertion failed");
`define PBB_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("path_bounding_box: assertion failed");
`else
`define PBB_ASSERT_SAME(label, clk, rst, ante, cons)
`define PBB_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// File: src/pbb_pkg.sv
// shared types and constants for the path bounding box block
// used by pbb_lane, pbb_merge, pbb_accum and path_bounding_box; no dependencies
package pbb_pkg;

  localparam int COORD_W   = 32;
  localparam int PROD_W    = 2 * COORD_W;
  localparam int EXPAND_W  = 31;
  localparam int REG_IDX_W = 3;
  localparam int LANES     = 3;
  localparam int NPTS      = LANES + 1;

  localparam logic signed [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
  localparam logic signed [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};
  localparam logic signed [COORD_W-1:0] UNITY     = 32'sh0001_0000;
  localparam logic [EXPAND_W-1:0]        EXPAND_RESET = 31'h0000_8000;

  typedef enum logic [1:0] {
    MODE_MOVE  = 2'd0,
    MODE_LINE  = 2'd1,
    MODE_CURVE = 2'd2,
    MODE_CLOSE = 2'd3
  } pbb_mode_e;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_MATRIX_A      = 3'd0,
    REG_MATRIX_B      = 3'd1,
    REG_MATRIX_C      = 3'd2,
    REG_MATRIX_D      = 3'd3,
    REG_MATRIX_E      = 3'd4,
    REG_MATRIX_F      = 3'd5,
    REG_STROKE_ENABLE = 3'd6,
    REG_STROKE_EXPAND = 3'd7
  } pbb_reg_e;

  typedef struct packed {
    pbb_mode_e                  mode;
    logic signed [COORD_W-1:0]  px1;
    logic signed [COORD_W-1:0]  py1;
    logic signed [COORD_W-1:0]  px2;
    logic signed [COORD_W-1:0]  py2;
    logic signed [COORD_W-1:0]  px3;
    logic signed [COORD_W-1:0]  py3;
    logic                       last_segment;
  } pbb_in_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] box_x_min;
    logic signed [COORD_W-1:0] box_y_min;
    logic signed [COORD_W-1:0] box_x_max;
    logic signed [COORD_W-1:0] box_y_max;
    logic                      box_has_points;
  } pbb_out_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] a;
    logic signed [COORD_W-1:0] b;
    logic signed [COORD_W-1:0] c;
    logic signed [COORD_W-1:0] d;
    logic signed [COORD_W-1:0] e;
    logic signed [COORD_W-1:0] f;
  } pbb_matrix_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] x_min;
    logic signed [COORD_W-1:0] y_min;
    logic signed [COORD_W-1:0] x_max;
    logic signed [COORD_W-1:0] y_max;
    logic                      has_pts;
  } pbb_box_t;

  typedef struct packed {
    logic load_prod;
    logic load_sum;
  } pbb_lane_ctl_t;

endpackage

// File: src/pbb_lane.sv
// one transform lane: maps a point through the affine matrix
// depends on pbb_pkg
module pbb_lane #(
  parameter int FRAC_BITS = 16
) (
  input  logic                                 clk,
  input  pbb_pkg::pbb_lane_ctl_t               ctl,
  input  pbb_pkg::pbb_matrix_t                 mat,
  input  logic signed [pbb_pkg::COORD_W-1:0]   x,
  input  logic signed [pbb_pkg::COORD_W-1:0]   y,
  output logic signed [pbb_pkg::COORD_W-1:0]   tx,
  output logic signed [pbb_pkg::COORD_W-1:0]   ty
);

  localparam int SUM_W = pbb_pkg::PROD_W + 2;
  localparam logic signed [SUM_W-1:0] HALF   = SUM_W'(1) <<< (FRAC_BITS - 1);
  localparam logic signed [SUM_W-1:0] SAT_HI = (SUM_W'(1) <<< (pbb_pkg::COORD_W - 1))
                                               - SUM_W'(1);
  localparam logic signed [SUM_W-1:0] SAT_LO = -(SUM_W'(1) <<< (pbb_pkg::COORD_W - 1));

  logic signed [pbb_pkg::PROD_W-1:0] p_ax, p_cy, p_bx, p_dy;

  // sum of products plus translation, rounded half up, saturated
  function automatic logic signed [pbb_pkg::COORD_W-1:0] round_sat(
    input logic signed [pbb_pkg::PROD_W-1:0]  p1,
    input logic signed [pbb_pkg::PROD_W-1:0]  p2,
    input logic signed [pbb_pkg::COORD_W-1:0] t
  );
    logic signed [SUM_W-1:0] acc;
    logic signed [SUM_W-1:0] q;
    acc = SUM_W'(p1) + SUM_W'(p2) + (SUM_W'(t) <<< FRAC_BITS) + HALF;
    q   = acc >>> FRAC_BITS;
    if (q > SAT_HI) begin
      return pbb_pkg::COORD_MAX;
    end else if (q < SAT_LO) begin
      return pbb_pkg::COORD_MIN;
    end
    return pbb_pkg::COORD_W'(q);
  endfunction

  // product stage
  always_ff @(posedge clk) begin
    if (ctl.load_prod) begin
      p_ax <= mat.a * x;
      p_cy <= mat.c * y;
      p_bx <= mat.b * x;
      p_dy <= mat.d * y;
    end
  end

  // round, translate and saturate stage
  always_ff @(posedge clk) begin
    if (ctl.load_sum) begin
      tx <= round_sat(p_ax, p_cy, mat.e);
      ty <= round_sat(p_bx, p_dy, mat.f);
    end
  end

endmodule

// File: src/pbb_merge.sv
// merging stage: folds the lane points and the origin into one item box
// depends on pbb_pkg
module pbb_merge (
  input  logic                                clk,
  input  logic                                load,
  input  logic [pbb_pkg::NPTS-1:0]            mask,
  input  logic signed [pbb_pkg::COORD_W-1:0]  origin_x,
  input  logic signed [pbb_pkg::COORD_W-1:0]  origin_y,
  input  logic signed [pbb_pkg::COORD_W-1:0]  pt_x [pbb_pkg::LANES],
  input  logic signed [pbb_pkg::COORD_W-1:0]  pt_y [pbb_pkg::LANES],
  output pbb_pkg::pbb_box_t                   item_box
);

  logic signed [pbb_pkg::COORD_W-1:0] all_x [pbb_pkg::NPTS];
  logic signed [pbb_pkg::COORD_W-1:0] all_y [pbb_pkg::NPTS];
  pbb_pkg::pbb_box_t                  box_next;

  always_comb begin
    all_x[0] = origin_x;
    all_y[0] = origin_y;
    for (int i = 0; i < pbb_pkg::LANES; i++) begin
      all_x[i+1] = pt_x[i];
      all_y[i+1] = pt_y[i];
    end
  end

  // points not present act as the identity of min and max
  always_comb begin
    box_next.x_min   = pbb_pkg::COORD_MAX;
    box_next.y_min   = pbb_pkg::COORD_MAX;
    box_next.x_max   = pbb_pkg::COORD_MIN;
    box_next.y_max   = pbb_pkg::COORD_MIN;
    box_next.has_pts = |mask;
    for (int i = 0; i < pbb_pkg::NPTS; i++) begin
      if (mask[i]) begin
        if (all_x[i] < box_next.x_min) box_next.x_min = all_x[i];
        if (all_y[i] < box_next.y_min) box_next.y_min = all_y[i];
        if (all_x[i] > box_next.x_max) box_next.x_max = all_x[i];
        if (all_y[i] > box_next.y_max) box_next.y_max = all_y[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item_box <= box_next;
    end
  end

endmodule

// File: src/pbb_accum.sv
// running box, stroke growth and result register
// depends on pbb_pkg
module pbb_accum (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          take,
  input  logic                          last,
  input  pbb_pkg::pbb_box_t             item_box,
  input  logic                          stroke_enable,
  input  logic [pbb_pkg::EXPAND_W-1:0]  stroke_expand,
  input  logic                          box_ready,
  output logic                          box_valid,
  output pbb_pkg::pbb_out_t             box
);

  localparam int GW = pbb_pkg::COORD_W + 2;
  localparam logic signed [GW-1:0] G_HI = GW'(pbb_pkg::COORD_MAX);
  localparam logic signed [GW-1:0] G_LO = GW'(pbb_pkg::COORD_MIN);

  pbb_pkg::pbb_box_t run;       // has_pts doubles as the path-started flag
  pbb_pkg::pbb_box_t merged;
  pbb_pkg::pbb_out_t box_next;

  function automatic logic signed [pbb_pkg::COORD_W-1:0] grow(
    input logic signed [pbb_pkg::COORD_W-1:0] v,
    input logic [pbb_pkg::EXPAND_W-1:0]       g,
    input logic                               up
  );
    logic signed [GW-1:0] gx;
    logic signed [GW-1:0] s;
    gx = $signed(GW'(g));
    s  = up ? GW'(v) + gx : GW'(v) - gx;
    if (s > G_HI) begin
      return pbb_pkg::COORD_MAX;
    end else if (s < G_LO) begin
      return pbb_pkg::COORD_MIN;
    end
    return pbb_pkg::COORD_W'(s);
  endfunction

  always_comb begin
    merged = run;
    if (item_box.has_pts) begin
      if (!run.has_pts) begin
        merged = item_box;
      end else begin
        merged.has_pts = 1'b1;
        if (item_box.x_min < run.x_min) merged.x_min = item_box.x_min;
        if (item_box.y_min < run.y_min) merged.y_min = item_box.y_min;
        if (item_box.x_max > run.x_max) merged.x_max = item_box.x_max;
        if (item_box.y_max > run.y_max) merged.y_max = item_box.y_max;
      end
    end
  end

  always_comb begin
    box_next.box_has_points = merged.has_pts;
    if (stroke_enable) begin
      box_next.box_x_min = grow(merged.x_min, stroke_expand, 1'b0);
      box_next.box_y_min = grow(merged.y_min, stroke_expand, 1'b0);
      box_next.box_x_max = grow(merged.x_max, stroke_expand, 1'b1);
      box_next.box_y_max = grow(merged.y_max, stroke_expand, 1'b1);
    end else begin
      box_next.box_x_min = merged.x_min;
      box_next.box_y_min = merged.y_min;
      box_next.box_x_max = merged.x_max;
      box_next.box_y_max = merged.y_max;
    end
  end

  // running state clears after the last item of a path
  always_ff @(posedge clk) begin
    if (rst) begin
      run <= '0;
    end else if (take) begin
      if (last) begin
        run <= '0;
      end else begin
        run <= merged;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      box_valid <= 1'b0;
    end else if (take && last) begin
      box_valid <= 1'b1;
    end else if (box_ready) begin
      box_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take && last) begin
      box <= box_next;
    end
  end

endmodule

// File: src/path_bounding_box.sv
// top level of the path bounding box block: config registers, pipeline control
// depends on pbb_pkg, pbb_lane, pbb_merge, pbb_accum, path_bounding_box_defines.svh
//
//   channel  | handshake             | payload
//   ---------+-----------------------+-----------------------------------------
//   seg      | seg_valid / seg_ready | pbb_in_t: one path segment per item
//   box      | box_valid / box_ready | pbb_out_t: box of the path, last item
//   cfg      | cfg_we                | cfg_index, cfg_data: register write
//
// one item per cycle unless a last item stalls on a waiting box; three transform
// lanes work on the points of an item at once; a path's box is formed in order by:
//   products load at acceptance, then round and saturate, merge, result register
// the running min/max compare is the only loop, one compare deep per cycle
// synchronous reset restores the matrix to identity, stroke off, margin 0.5,
// and clears the running box; no clearing pass is needed
// while a box waits, non-last items keep flowing; a last item stalls at the
// merging stage until the result register is free
`include "path_bounding_box_defines.svh"

module path_bounding_box #(
  parameter int FRAC_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [pbb_pkg::REG_IDX_W-1:0]     cfg_index,
  input  logic [pbb_pkg::COORD_W-1:0]       cfg_data,
  input  logic                              seg_valid,
  output logic                              seg_ready,
  input  pbb_pkg::pbb_in_t                  seg,
  output logic                              box_valid,
  input  logic                              box_ready,
  output pbb_pkg::pbb_out_t                 box
);

  // configuration registers
  pbb_pkg::pbb_matrix_t               mat;
  logic                               stroke_enable;
  logic [pbb_pkg::EXPAND_W-1:0]       stroke_expand;

  // front end: whether the path has a point yet, as seen at acceptance
  logic                               front_started;
  logic                               seg_take;
  logic                               is_close;
  logic                               is_curve;
  logic [pbb_pkg::NPTS-1:0]           seg_mask;

  // stage control: valid and last flag per stage, point mask for the first two
  logic                               s1_valid, s2_valid, s3_valid;
  logic [pbb_pkg::NPTS-1:0]           s1_mask, s2_mask;
  logic                               s1_last, s2_last, s3_last;
  logic                               s1_free, s2_free, s3_free, s3_take;

  pbb_pkg::pbb_lane_ctl_t             lane_ctl;
  logic signed [pbb_pkg::COORD_W-1:0] lane_x  [pbb_pkg::LANES];
  logic signed [pbb_pkg::COORD_W-1:0] lane_y  [pbb_pkg::LANES];
  logic signed [pbb_pkg::COORD_W-1:0] pt_x    [pbb_pkg::LANES];
  logic signed [pbb_pkg::COORD_W-1:0] pt_y    [pbb_pkg::LANES];
  pbb_pkg::pbb_box_t                  item_box;

  // register writes, taken at any time the enable is high
  always_ff @(posedge clk) begin
    if (rst) begin
      mat.a         <= pbb_pkg::UNITY;
      mat.b         <= '0;
      mat.c         <= '0;
      mat.d         <= pbb_pkg::UNITY;
      mat.e         <= '0;
      mat.f         <= '0;
      stroke_enable <= 1'b0;
      stroke_expand <= pbb_pkg::EXPAND_RESET;
    end else if (cfg_we) begin
      unique case (pbb_pkg::pbb_reg_e'(cfg_index))
        pbb_pkg::REG_MATRIX_A:      mat.a         <= cfg_data;
        pbb_pkg::REG_MATRIX_B:      mat.b         <= cfg_data;
        pbb_pkg::REG_MATRIX_C:      mat.c         <= cfg_data;
        pbb_pkg::REG_MATRIX_D:      mat.d         <= cfg_data;
        pbb_pkg::REG_MATRIX_E:      mat.e         <= cfg_data;
        pbb_pkg::REG_MATRIX_F:      mat.f         <= cfg_data;
        pbb_pkg::REG_STROKE_ENABLE: stroke_enable <= cfg_data[0];
        pbb_pkg::REG_STROKE_EXPAND: stroke_expand <= cfg_data[pbb_pkg::EXPAND_W-1:0];
        default: ;
      endcase
    end
  end

  // ready chain: each stage moves when the one after it is free
  assign s3_take   = s3_valid && (!s3_last || !box_valid || box_ready);
  assign s3_free   = !s3_valid || s3_take;
  assign s2_free   = !s2_valid || s3_free;
  assign s1_free   = !s1_valid || s2_free;
  assign seg_ready = s1_free;
  assign seg_take  = seg_valid && seg_ready;

  assign lane_ctl.load_prod = s1_free;
  assign lane_ctl.load_sum  = s2_free;

  // point mask: origin, then the first, second and third point
  // a line or curve on a path with no point yet brings in the origin first
  assign is_close    = (seg.mode == pbb_pkg::MODE_CLOSE);
  assign is_curve    = (seg.mode == pbb_pkg::MODE_CURVE);
  assign seg_mask[0] = !front_started && (seg.mode == pbb_pkg::MODE_LINE || is_curve);
  assign seg_mask[1] = !is_close;
  assign seg_mask[2] = is_curve;
  assign seg_mask[3] = is_curve;

  always_ff @(posedge clk) begin
    if (rst) begin
      front_started <= 1'b0;
    end else if (seg_take) begin
      if (seg.last_segment) begin
        front_started <= 1'b0;
      end else if (!is_close) begin
        front_started <= 1'b1;
      end
    end
  end

  // stage valids
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
    end else begin
      if (s1_free) s1_valid <= seg_valid;
      if (s2_free) s2_valid <= s1_valid;
      if (s3_free) s3_valid <= s2_valid;
    end
  end

  // side information travelling with the item
  always_ff @(posedge clk) begin
    if (s1_free) begin
      s1_mask <= seg_mask;
      s1_last <= seg.last_segment;
    end
    if (s2_free) begin
      s2_mask <= s1_mask;
      s2_last <= s1_last;
    end
    if (s3_free) begin
      s3_last <= s2_last;
    end
  end

  assign lane_x[0] = seg.px1;
  assign lane_y[0] = seg.py1;
  assign lane_x[1] = seg.px2;
  assign lane_y[1] = seg.py2;
  assign lane_x[2] = seg.px3;
  assign lane_y[2] = seg.py3;

  for (genvar g = 0; g < pbb_pkg::LANES; g++) begin : g_lane
    pbb_lane #(
      .FRAC_BITS (FRAC_BITS)
    ) u_lane (
      .clk (clk),
      .ctl (lane_ctl),
      .mat (mat),
      .x   (lane_x[g]),
      .y   (lane_y[g]),
      .tx  (pt_x[g]),
      .ty  (pt_y[g])
    );
  end

  // the origin maps exactly onto the translation
  pbb_merge u_merge (
    .clk      (clk),
    .load     (s3_free),
    .mask     (s2_mask),
    .origin_x (mat.e),
    .origin_y (mat.f),
    .pt_x     (pt_x),
    .pt_y     (pt_y),
    .item_box (item_box)
  );

  pbb_accum u_accum (
    .clk           (clk),
    .rst           (rst),
    .take          (s3_take),
    .last          (s3_last),
    .item_box      (item_box),
    .stroke_enable (stroke_enable),
    .stroke_expand (stroke_expand),
    .box_ready     (box_ready),
    .box_valid     (box_valid),
    .box           (box)
  );

  // a last item leaving the merging stage always lands in the result register
  `PBB_ASSERT_NEXT(a_last_gives_box, clk, rst, s3_take && s3_last, box_valid)
  // the input side never stalls while the result register is empty
  `PBB_ASSERT_SAME(a_ready_when_drained, clk, rst, !box_valid, seg_ready)
  // acceptance of a last item starts a fresh path
  `PBB_ASSERT_NEXT(a_path_restart, clk, rst, seg_take && seg.last_segment, !front_started)
  // a delivered box is never inverted
  `PBB_ASSERT_SAME(a_box_ordered, clk, rst, box_valid,
                   box.box_x_min <= box.box_x_max && box.box_y_min <= box.box_y_max)

endmodule

// File: dv/path_bounding_box_tb.sv
// self-checking testbench for path_bounding_box: directed stimulus table, then random paths
// depends on pbb_pkg and path_bounding_box; the box predictor is built in here
`timescale 1ns / 100ps

module path_bounding_box_tb;
  import pbb_pkg::*;

  localparam int FRAC = 16;
  localparam logic signed [65:0] HALF_LSB = 66'sd1 <<< (FRAC - 1);

  // one row of the directed table: either a register write or a segment,
  // optionally with the box typed in by hand
  typedef struct {
    bit          is_cfg;
    pbb_reg_e    idx;
    logic [31:0] data;
    pbb_in_t     s;
    bit          typed;
    pbb_out_t    want;
  } step_t;

  logic     clk = 1'b0;
  logic     rst;
  logic     cfg_we;
  pbb_reg_e cfg_index;
  logic [COORD_W-1:0] cfg_data;
  logic     seg_valid;
  logic     seg_ready;
  pbb_in_t  seg;
  logic     box_valid;
  logic     box_ready;
  pbb_out_t box;

  // shadow of the block's registers and running box
  logic signed [31:0] coef [6];
  logic               stroke_on;
  logic [30:0]        margin;
  logic               trk_started;
  logic signed [31:0] trk_x_min, trk_y_min, trk_x_max, trk_y_max;

  pbb_out_t pending_boxes [$];
  step_t    plan [$];
  int       mismatches = 0;
  bit       sender_idle = 1'b1;
  bit       sink_idle = 1'b1;
  bit       hold_req = 1'b0;

  path_bounding_box #(.FRAC_BITS(FRAC)) dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .seg_valid (seg_valid),
    .seg_ready (seg_ready),
    .seg       (seg),
    .box_valid (box_valid),
    .box_ready (box_ready),
    .box       (box)
  );

  always #4 clk = ~clk;

  // hard stop well beyond the slowest legal run
  initial begin
    #3_000_000;
    $display("** path_bounding_box: FAILED **");
    $finish;
  end

  // ---------------------------------------------------------------- predictor

  function automatic logic signed [31:0] clamp(input logic signed [65:0] v);
    if (v > COORD_MAX) return COORD_MAX;
    if (v < COORD_MIN) return COORD_MIN;
    return v[31:0];
  endfunction

  // k1*v1 + k2*v2 exact, rounded half up to the fraction grid, plus offset,
  // saturated; 66 bits hold the sum of two extreme products without wrap
  function automatic logic signed [31:0] map_coord(input logic signed [31:0] k1, v1,
                                                   input logic signed [31:0] k2, v2, t);
    logic signed [65:0] w1, w2, w3, w4, wt, acc;
    w1 = k1; w2 = v1; w3 = k2; w4 = v2; wt = t;
    acc = w1 * w2 + w3 * w4 + HALF_LSB;
    acc = (acc >>> FRAC) + wt;
    return clamp(acc);
  endfunction

  function automatic void add_point(input logic signed [31:0] x, y);
    logic signed [31:0] tx, ty;
    tx = map_coord(coef[REG_MATRIX_A], x, coef[REG_MATRIX_C], y, coef[REG_MATRIX_E]);
    ty = map_coord(coef[REG_MATRIX_B], x, coef[REG_MATRIX_D], y, coef[REG_MATRIX_F]);
    if (!trk_started) begin
      trk_x_min = tx; trk_x_max = tx;
      trk_y_min = ty; trk_y_max = ty;
      trk_started = 1'b1;
    end else begin
      if (tx < trk_x_min) trk_x_min = tx;
      if (ty < trk_y_min) trk_y_min = ty;
      if (tx > trk_x_max) trk_x_max = tx;
      if (ty > trk_y_max) trk_y_max = ty;
    end
  endfunction

  function automatic void clear_path();
    trk_started = 1'b0;
    trk_x_min = '0; trk_y_min = '0; trk_x_max = '0; trk_y_max = '0;
  endfunction

  function automatic void predict_segment(input pbb_in_t s, output bit emits,
                                          output pbb_out_t o);
    logic signed [65:0] grow;
    // a line or curve with no point yet starts from the origin
    if ((s.mode == MODE_LINE || s.mode == MODE_CURVE) && !trk_started)
      add_point('0, '0);
    case (s.mode)
      MODE_CURVE: begin
        add_point(s.px1, s.py1);
        add_point(s.px2, s.py2);
        add_point(s.px3, s.py3);
      end
      MODE_MOVE, MODE_LINE: add_point(s.px1, s.py1);
      default: ;
    endcase
    emits = s.last_segment;
    o = '0;
    if (emits) begin
      grow = stroke_on ? {35'd0, margin} : 66'sd0;
      o.box_x_min = clamp(66'(trk_x_min) - grow);
      o.box_y_min = clamp(66'(trk_y_min) - grow);
      o.box_x_max = clamp(66'(trk_x_max) + grow);
      o.box_y_max = clamp(66'(trk_y_max) + grow);
      o.box_has_points = trk_started;
      clear_path();
    end
  endfunction

  function automatic void reset_shadow();
    coef[REG_MATRIX_A] = UNITY;
    coef[REG_MATRIX_B] = '0;
    coef[REG_MATRIX_C] = '0;
    coef[REG_MATRIX_D] = UNITY;
    coef[REG_MATRIX_E] = '0;
    coef[REG_MATRIX_F] = '0;
    stroke_on = 1'b0;
    margin = EXPAND_RESET;
    clear_path();
  endfunction

  // ---------------------------------------------------------------- stimulus helpers

  function automatic step_t seg_row(input pbb_mode_e m, input logic [31:0] x1, y1,
                                    input logic [31:0] x2, y2, x3, y3, input bit last);
    step_t r;
    r = '{idx: REG_MATRIX_A, default: '0};
    r.s.mode = m;
    r.s.px1 = x1; r.s.py1 = y1;
    r.s.px2 = x2; r.s.py2 = y2;
    r.s.px3 = x3; r.s.py3 = y3;
    r.s.last_segment = last;
    return r;
  endfunction

  function automatic step_t with_box(input step_t r, input pbb_out_t w);
    r.typed = 1'b1;
    r.want = w;
    return r;
  endfunction

  function automatic step_t cfg_row(input pbb_reg_e idx, input logic [31:0] val);
    step_t r;
    r = '{idx: REG_MATRIX_A, default: '0};
    r.is_cfg = 1'b1;
    r.idx = idx;
    r.data = val;
    return r;
  endfunction

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 9))
      0: return COORD_MAX;
      1: return COORD_MIN;
      2: return $urandom_range(0, 32'h3_FFFF) - 32'h2_0000;
      3, 4, 5: return $urandom;
      default: return $urandom_range(0, 2000 * 65536) - 1000 * 65536;
    endcase
  endfunction

  function automatic logic [31:0] rand_coef();
    case ($urandom_range(0, 9))
      0: return UNITY;
      1: return '0;
      2, 3: return $urandom;
      4: return COORD_MIN;
      5: return COORD_MAX;
      default: return $urandom_range(0, 8 * 65536) - 4 * 65536;
    endcase
  endfunction

  function automatic pbb_in_t rand_seg(input pbb_mode_e m, input bit last);
    pbb_in_t s;
    s.mode = m;
    s.px1 = rand_coord(); s.py1 = rand_coord();
    s.px2 = rand_coord(); s.py2 = rand_coord();
    s.px3 = rand_coord(); s.py3 = rand_coord();
    s.last_segment = last;
    return s;
  endfunction

  // offer one item and hold it until taken; the box is predicted at acceptance
  task automatic push_segment(input pbb_in_t s, input bit typed, input pbb_out_t want);
    int       gap;
    bit       emits;
    pbb_out_t predicted;
    @(negedge clk);
    if (sender_idle && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 17);
      seg_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    seg = s;
    seg_valid = 1'b1;
    @(posedge clk);
    while (!seg_ready) @(posedge clk);
    predict_segment(s, emits, predicted);
    if (emits) pending_boxes.push_back(typed ? want : predicted);
  endtask

  // register writes only once the pipe is empty: all boxes out, and items that
  // produce no box given time to drain
  task automatic set_reg(input pbb_reg_e idx, input logic [31:0] val);
    @(negedge clk);
    seg_valid = 1'b0;
    while (pending_boxes.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    cfg_index = idx;
    cfg_data = val;
    cfg_we = 1'b1;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      REG_STROKE_ENABLE: stroke_on = val[0];
      REG_STROKE_EXPAND: margin = val[30:0];
      default:           coef[idx] = val;
    endcase
  endtask

  // mostly well-formed paths starting with a move; some stray items between
  task automatic run_paths(input int count, input int max_len);
    int        n, len;
    pbb_mode_e m;
    n = 0;
    while (n < count) begin
      if ($urandom_range(0, 4) == 0) begin
        push_segment(rand_seg(pbb_mode_e'($urandom_range(0, 3)), $urandom_range(0, 3) == 0),
                     1'b0, '0);
        n++;
      end else begin
        len = $urandom_range(1, max_len);
        for (int i = 0; i < len; i++) begin
          if (i == 0) begin
            m = ($urandom_range(0, 3) != 0) ? MODE_MOVE : pbb_mode_e'($urandom_range(1, 2));
          end else begin
            case ($urandom_range(0, 9))
              0:          m = MODE_MOVE;
              1:          m = MODE_CLOSE;
              2, 3, 4, 5: m = MODE_LINE;
              default:    m = MODE_CURVE;
            endcase
          end
          push_segment(rand_seg(m, i == len - 1), 1'b0, '0);
          n++;
        end
      end
    end
  endtask

  task automatic report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 40) $display("%0t: %s", $time, msg);
  endtask

  // ---------------------------------------------------------------- box side

  // ready side: random stall bursts, plus one long hold-off on request so the
  // pipe backs up into the segment input
  initial begin
    box_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        box_ready = 1'b0;
        repeat (400) @(negedge clk);
        box_ready = 1'b1;
      end else if (sink_idle && $urandom_range(0, 5) == 0) begin
        box_ready = 1'b0;
        repeat ($urandom_range(1, 17)) @(negedge clk);
        box_ready = 1'b1;
      end else begin
        box_ready = 1'b1;
      end
    end
  end

  // each box taken is matched against the oldest one predicted
  always @(posedge clk) begin
    pbb_out_t want;
    if (!rst && box_valid && box_ready) begin
      if (pending_boxes.size() == 0) begin
        report_mismatch($sformatf("box with nothing pending: %h", box));
      end else begin
        want = pending_boxes.pop_front();
        if (box.box_x_min !== want.box_x_min)
          report_mismatch($sformatf("box_x_min %h, want %h", box.box_x_min, want.box_x_min));
        if (box.box_y_min !== want.box_y_min)
          report_mismatch($sformatf("box_y_min %h, want %h", box.box_y_min, want.box_y_min));
        if (box.box_x_max !== want.box_x_max)
          report_mismatch($sformatf("box_x_max %h, want %h", box.box_x_max, want.box_x_max));
        if (box.box_y_max !== want.box_y_max)
          report_mismatch($sformatf("box_y_max %h, want %h", box.box_y_max, want.box_y_max));
        if (box.box_has_points !== want.box_has_points)
          report_mismatch($sformatf("box_has_points %b, want %b",
                                    box.box_has_points, want.box_has_points));
      end
    end
  end

  // ---------------------------------------------------------------- main sequence

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = REG_MATRIX_A;
    cfg_data = '0;
    seg_valid = 1'b0;
    seg = '0;
    reset_shadow();

    // directed table; identity matrix and no stroke out of reset
    // empty path gives an all-zero box
    plan.push_back(with_box(seg_row(MODE_CLOSE, 0, 0, 0, 0, 0, 0, 1),
                            '{32'sh0, 32'sh0, 32'sh0, 32'sh0, 1'b0}));
    // coordinate extremes pass through identity untouched
    plan.push_back(with_box(seg_row(MODE_MOVE, COORD_MAX, COORD_MIN, 0, 0, 0, 0, 1),
                            '{COORD_MAX, COORD_MIN, COORD_MAX, COORD_MIN, 1'b1}));
    // line with no point yet pulls in the origin
    plan.push_back(with_box(seg_row(MODE_LINE, 32'sh0005_0000, 32'shFFFD_0000, 0, 0, 0, 0, 1),
                            '{32'sh0, 32'shFFFD_0000, 32'sh0005_0000, 32'sh0, 1'b1}));
    plan.push_back(seg_row(MODE_CURVE, COORD_MIN, COORD_MAX, 32'hFFFF_FFFF, 32'h1,
                           32'h1234_5678, 32'hEDCB_A988, 0));
    plan.push_back(seg_row(MODE_CLOSE, 0, 0, 0, 0, 0, 0, 0));
    plan.push_back(seg_row(MODE_LINE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0, 0, 0, 0));
    plan.push_back(seg_row(MODE_MOVE, 32'h7FFF_0000, 32'h1, 0, 0, 0, 0, 1));
    // close on an unstarted path adds nothing
    plan.push_back(seg_row(MODE_CLOSE, 32'h1234, 32'h5678, 0, 0, 0, 0, 0));
    plan.push_back(with_box(seg_row(MODE_CLOSE, 0, 0, 0, 0, 0, 0, 1),
                            '{32'sh0, 32'sh0, 32'sh0, 32'sh0, 1'b0}));
    plan.push_back(seg_row(MODE_CURVE, 32'h0003_8000, 32'hFFFE_0000, 32'h0001_0000,
                           32'h0004_4000, 32'hFFFF_C000, 32'h0000_0001, 1));
    // half-scale matrix to hit rounding ties, extreme other coefficients
    plan.push_back(cfg_row(REG_MATRIX_A, 32'h0000_8000));
    plan.push_back(cfg_row(REG_MATRIX_B, COORD_MIN));
    plan.push_back(cfg_row(REG_MATRIX_C, COORD_MAX));
    plan.push_back(cfg_row(REG_MATRIX_D, 32'hFFFF_FFFF));
    plan.push_back(cfg_row(REG_MATRIX_E, COORD_MAX));
    plan.push_back(cfg_row(REG_MATRIX_F, COORD_MIN));
    plan.push_back(seg_row(MODE_MOVE, 32'h1, 32'h1, 0, 0, 0, 0, 0));
    plan.push_back(seg_row(MODE_MOVE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0, 0, 0, 0));
    plan.push_back(seg_row(MODE_LINE, COORD_MIN, COORD_MIN, 0, 0, 0, 0, 1));
    plan.push_back(seg_row(MODE_CURVE, COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX,
                           32'h1, 32'hFFFF_FFFF, 1));
    // both products at their largest, sum must not wrap
    plan.push_back(cfg_row(REG_MATRIX_A, COORD_MIN));
    plan.push_back(cfg_row(REG_MATRIX_B, COORD_MIN));
    plan.push_back(cfg_row(REG_MATRIX_C, COORD_MIN));
    plan.push_back(cfg_row(REG_MATRIX_D, COORD_MIN));
    plan.push_back(cfg_row(REG_MATRIX_E, 32'h0));
    plan.push_back(cfg_row(REG_MATRIX_F, 32'h0));
    plan.push_back(seg_row(MODE_MOVE, COORD_MIN, COORD_MIN, 0, 0, 0, 0, 1));
    plan.push_back(seg_row(MODE_MOVE, COORD_MAX, COORD_MIN, 0, 0, 0, 0, 1));
    // back to identity, stroke on with the reset margin of one half
    plan.push_back(cfg_row(REG_MATRIX_A, UNITY));
    plan.push_back(cfg_row(REG_MATRIX_B, 32'h0));
    plan.push_back(cfg_row(REG_MATRIX_C, 32'h0));
    plan.push_back(cfg_row(REG_MATRIX_D, UNITY));
    plan.push_back(cfg_row(REG_STROKE_ENABLE, 32'h1));
    // empty path is still grown by the margin
    plan.push_back(with_box(seg_row(MODE_CLOSE, 0, 0, 0, 0, 0, 0, 1),
                            '{32'shFFFF_8000, 32'shFFFF_8000, 32'sh0000_8000,
                              32'sh0000_8000, 1'b0}));
    // widest margin, upper bits of the write dropped; growth saturates
    plan.push_back(cfg_row(REG_STROKE_EXPAND, 32'hFFFF_FFFF));
    plan.push_back(with_box(seg_row(MODE_MOVE, COORD_MAX, COORD_MIN, 0, 0, 0, 0, 1),
                            '{32'sh0, COORD_MIN, COORD_MAX, 32'shFFFF_FFFF, 1'b1}));
    plan.push_back(seg_row(MODE_LINE, UNITY, UNITY, 0, 0, 0, 0, 1));
    plan.push_back(cfg_row(REG_STROKE_ENABLE, 32'hFFFF_FFFE));

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (plan[i]) begin
      if (plan[i].is_cfg)
        set_reg(plan[i].idx, plan[i].data);
      else
        push_segment(plan[i].s, plan[i].typed, plan[i].want);
    end

    // random phases, each under its own register setting
    for (int ph = 0; ph < 7; ph++) begin
      case (ph)
        0: ;
        1: for (int r = 0; r < 8; r++) set_reg(pbb_reg_e'(r), 32'h7FFF_FFFF);
        2: for (int r = 0; r < 8; r++) set_reg(pbb_reg_e'(r), 32'h8000_0000);
        3: begin
          set_reg(REG_MATRIX_A, UNITY);
          set_reg(REG_MATRIX_B, 32'h0);
          set_reg(REG_MATRIX_C, 32'h0);
          set_reg(REG_MATRIX_D, UNITY);
          set_reg(REG_MATRIX_E, 32'h0);
          set_reg(REG_MATRIX_F, 32'h0);
          set_reg(REG_STROKE_ENABLE, 32'h1);
          set_reg(REG_STROKE_EXPAND, 32'h0);
        end
        default: begin
          for (int r = 0; r < 6; r++) set_reg(pbb_reg_e'(r), rand_coef());
          set_reg(REG_STROKE_ENABLE, $urandom);
          set_reg(REG_STROKE_EXPAND,
                  $urandom_range(0, 1) ? $urandom : $urandom_range(0, 32'h4_0000));
        end
      endcase
      // phase 4: no gaps, box side held off so short paths back up the pipe
      // phase 6: no idling at all
      sender_idle = (ph != 4 && ph != 6);
      sink_idle = (ph != 6);
      if (ph == 4) hold_req = 1'b1;
      run_paths(65, (ph == 4) ? 2 : 8);
    end

    @(negedge clk);
    seg_valid = 1'b0;
    while (pending_boxes.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatches == 0)
      $display("** path_bounding_box: PASSED **");
    else
      $display("** path_bounding_box: FAILED **");
    $finish;
  end

endmodule

// File: files.f
+incdir+src
src/pbb_pkg.sv
src/pbb_lane.sv
src/pbb_merge.sv
src/pbb_accum.sv
src/path_bounding_box.sv
dv/path_bounding_box_tb.sv
